// ===== sv/lpfr_pkg.sv =====
// ----------------------------------------------------------------------------
// lpfr_pkg: shared definitions for the length-prefixed frame receiver
// Field widths, register indexes, reset values and the parser and result
// codes used by the interfaces and the receiver.
// ----------------------------------------------------------------------------
package lpfr_pkg;

   localparam int ByteWidth     = 8;
   localparam int CrcWidth      = 16;
   localparam int KindWidth     = 2;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 8;

   localparam logic [CsrIndexWidth-1:0] CsrStartDelimiter = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrEndDelimiter   = 2'd1;

   localparam logic [ByteWidth-1:0] StartDelimiterReset = 8'd2;
   localparam logic [ByteWidth-1:0] EndDelimiterReset   = 8'd3;

   typedef enum logic [2:0] {
      SegStart  = 3'd0,
      SegId     = 3'd1,
      SegLength = 3'd2,
      SegData   = 3'd3,
      SegCrc    = 3'd4,
      SegEnd    = 3'd5
   } segment_type;

   typedef enum logic [KindWidth-1:0] {
      KindPayload  = 2'd0,
      KindAccepted = 2'd1,
      KindDropped  = 2'd2
   } kind_type;

endpackage

// ===== sv/lpfr_if.sv =====
// ----------------------------------------------------------------------------
// lpfr_req_if / lpfr_rsp_if: request and result channels of the receiver
// Valid/ready channels; an item moves at a clock edge with both high.
// ----------------------------------------------------------------------------
interface lpfr_req_if;
   logic                           valid;
   logic                           ready;
   logic [lpfr_pkg::ByteWidth-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lpfr_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [lpfr_pkg::KindWidth-1:0] result_kind;
   logic [lpfr_pkg::ByteWidth-1:0] frame_id;
   logic [lpfr_pkg::ByteWidth-1:0] frame_length;
   logic [lpfr_pkg::ByteWidth-1:0] payload_byte;
   logic [lpfr_pkg::ByteWidth-1:0] payload_index;
   logic [lpfr_pkg::CrcWidth-1:0]  frame_crc;

   modport source (output valid, output result_kind, output frame_id,
                   output frame_length, output payload_byte,
                   output payload_index, output frame_crc, input ready);
   modport sink   (input valid, input result_kind, input frame_id,
                   input frame_length, input payload_byte,
                   input payload_index, input frame_crc, output ready);
endinterface

// ===== sv/length_prefixed_frame_receiver.sv =====
// Path: a request byte that yields a result passes through the input register,
// then the result register, before it shows on rsp.
// Throughput: one byte per cycle while rsp is not stalled; the parser state updates once per byte.
// Reset: synchronous; the parser returns to waiting for a start delimiter,
// captured fields clear and the delimiters go back to 2 and 3.
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver: byte-wise deframer
// Finds start delimiter, id, length, payload, CRC and end delimiter and
// reports each payload byte and a frame-done result.
// ----------------------------------------------------------------------------
module length_prefixed_frame_receiver (
   input  logic                               clock,
   input  logic                               reset,
   lpfr_req_if.sink                           req_chan,
   lpfr_rsp_if.source                         rsp_chan,
   input  logic                               csr_write_enable,
   input  logic [lpfr_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [lpfr_pkg::CsrDataWidth-1:0]  csr_write_data
);

   localparam int BW = lpfr_pkg::ByteWidth;

   // Configuration.
   logic [BW-1:0] start_delim_ff;
   logic [BW-1:0] end_delim_ff;

   // Input register.
   logic          in_valid_ff;
   logic [BW-1:0] in_byte_ff;

   // Parser state.
   lpfr_pkg::segment_type seg_ff, seg_in;
   logic [BW-1:0]                   count_ff, count_in;
   logic [BW-1:0]                   length_ff, length_in;
   logic [BW-1:0]                   id_ff, id_in;
   logic [lpfr_pkg::CrcWidth-1:0]   crc_ff, crc_in;

   // Result of the byte being processed.
   logic                            res_valid;
   lpfr_pkg::kind_type              res_kind;
   logic [BW-1:0]                   res_payload;
   logic [BW-1:0]                   res_index;
   logic [lpfr_pkg::CrcWidth-1:0]   res_crc;
   logic [BW-1:0]                   count_plus;

   // Result register.
   logic                            out_valid_ff;
   lpfr_pkg::kind_type              out_kind_ff;
   logic [BW-1:0]                   out_id_ff;
   logic [BW-1:0]                   out_length_ff;
   logic [BW-1:0]                   out_payload_ff;
   logic [BW-1:0]                   out_index_ff;
   logic [lpfr_pkg::CrcWidth-1:0]   out_crc_ff;

   logic advance;
   logic process;

   // The pipeline moves whenever the result register is empty or drained.
   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign process        = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_delim_ff <= lpfr_pkg::StartDelimiterReset;
         end_delim_ff   <= lpfr_pkg::EndDelimiterReset;
      end else if (csr_write_enable) begin
         if (csr_index == lpfr_pkg::CsrStartDelimiter) begin
            start_delim_ff <= csr_write_data;
         end else if (csr_index == lpfr_pkg::CsrEndDelimiter) begin
            end_delim_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_byte_ff <= req_chan.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff    <= lpfr_pkg::SegStart;
         count_ff  <= '0;
         length_ff <= '0;
         id_ff     <= '0;
         crc_ff    <= '0;
      end else if (process) begin
         seg_ff    <= seg_in;
         count_ff  <= count_in;
         length_ff <= length_in;
         id_ff     <= id_in;
         crc_ff    <= crc_in;
      end
   end

   assign count_plus = count_ff + {{(BW-1){1'b0}}, 1'b1};

   always_comb begin
      seg_in      = seg_ff;
      count_in    = count_ff;
      length_in   = length_ff;
      id_in       = id_ff;
      crc_in      = crc_ff;
      res_valid   = 1'b0;
      res_kind    = lpfr_pkg::KindPayload;
      res_payload = '0;
      res_index   = '0;
      res_crc     = '0;
      unique case (seg_ff)
         lpfr_pkg::SegId: begin
            id_in  = in_byte_ff;
            seg_in = lpfr_pkg::SegLength;
         end
         lpfr_pkg::SegLength: begin
            length_in = in_byte_ff;
            count_in  = '0;
            seg_in    = (in_byte_ff == '0) ? lpfr_pkg::SegCrc : lpfr_pkg::SegData;
         end
         lpfr_pkg::SegData: begin
            res_valid   = 1'b1;
            res_payload = in_byte_ff;
            res_index   = count_ff;
            if (count_plus == length_ff) begin
               count_in = '0;
               seg_in   = lpfr_pkg::SegCrc;
            end else begin
               count_in = count_plus;
            end
         end
         lpfr_pkg::SegCrc: begin
            if (count_ff == '0) begin
               crc_in   = {crc_ff[lpfr_pkg::CrcWidth-1:BW], in_byte_ff};
               count_in = {{(BW-1){1'b0}}, 1'b1};
            end else begin
               crc_in   = {in_byte_ff, crc_ff[BW-1:0]};
               count_in = '0;
               seg_in   = lpfr_pkg::SegEnd;
            end
         end
         lpfr_pkg::SegEnd: begin
            // The end byte always closes the frame, right or wrong.
            res_valid = 1'b1;
            res_kind  = (in_byte_ff == end_delim_ff) ? lpfr_pkg::KindAccepted
                                                     : lpfr_pkg::KindDropped;
            res_crc   = crc_ff;
            seg_in    = lpfr_pkg::SegStart;
            count_in  = '0;
            length_in = '0;
            crc_in    = '0;
         end
         default: begin
            seg_in = (in_byte_ff == start_delim_ff) ? lpfr_pkg::SegId
                                                    : lpfr_pkg::SegStart;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= process && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (process && res_valid) begin
         out_kind_ff    <= res_kind;
         out_id_ff      <= id_ff;
         out_length_ff  <= length_ff;
         out_payload_ff <= res_payload;
         out_index_ff   <= res_index;
         out_crc_ff     <= res_crc;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.result_kind   = out_kind_ff;
   assign rsp_chan.frame_id      = out_id_ff;
   assign rsp_chan.frame_length  = out_length_ff;
   assign rsp_chan.payload_byte  = out_payload_ff;
   assign rsp_chan.payload_index = out_index_ff;
   assign rsp_chan.frame_crc     = out_crc_ff;

endmodule
